// File: src/sltbs_pkg.sv
// Package for the sorted-table lower-bound search block.
// Holds field widths, operation codes, state and command types.
// No dependencies; every other file of the block but sltbs_ram uses it.
package sltbs_pkg;

	// Field widths fixed by the item format
	localparam int unsigned IDX_W = 10;
	localparam int unsigned POS_W = 11;
	localparam int unsigned VAL_W = 64;
	// Search bounds: signed, wide enough for -1 and for last index + 1
	localparam int unsigned CNT_W = 12;

	// Input operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK_RD,
		ST_CHK_CMP,
		ST_PROBE_RD,
		ST_PROBE_CMP,
		ST_WALK_RD,
		ST_WALK_CMP
	} state_t;

	// Table read address source
	typedef enum logic [1:0] {
		RD_NONE,
		RD_HI,
		RD_MID,
		RD_PREV
	} rd_sel_t;

	// Result kind
	typedef enum logic [1:0] {
		RES_BEYOND,
		RES_MISS,
		RES_HIT
	} res_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic     capture;
		logic     wr_en;
		rd_sel_t  rd_sel;
		logic     probe_step;
		logic     hit_mark;
		logic     walk_dec;
		logic     res_load;
		res_sel_t res_sel;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic beyond;
		logic eq;
		logic loop_ok;
		logic walk_ok;
	} status_t;

endpackage

// File: src/sltbs_req_if.sv
// Request channel interface: load and query items with valid/ready.
// Depends on sltbs_pkg for field widths.
interface sltbs_req_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic [sltbs_pkg::IDX_W-1:0]         entry_index;
	logic signed [sltbs_pkg::VAL_W-1:0]  entry_value;
	logic [sltbs_pkg::IDX_W-1:0]         start_index;
	logic signed [sltbs_pkg::VAL_W-1:0]  key;

	modport source (output valid, op, entry_index, entry_value, start_index, key,
		input ready);
	modport sink (input valid, op, entry_index, entry_value, start_index, key,
		output ready);
endinterface

// File: src/sltbs_rsp_if.sv
// Response channel interface: search results with valid/ready.
// Depends on sltbs_pkg for field widths.
interface sltbs_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [sltbs_pkg::POS_W-1:0] position;
	logic                        found;
	logic                        beyond_end;

	modport source (output valid, position, found, beyond_end, input ready);
	modport sink (input valid, position, found, beyond_end, output ready);
endinterface

// File: src/sorted_table_lower_bound_search.sv
// Top level of the sorted-table lower-bound search block.
// Depends on sltbs_pkg, sltbs_req_if, sltbs_rsp_if, sltbs_ctrl and sltbs_dp.
//
//   channel   direction  handshake       payload
//   req       in         valid/ready     op, entry_index, entry_value, start_index, key
//   rsp       out        valid/ready     position, found, beyond_end
//   cfg       in         cfg_we          cfg_wdata (last_index)
//
// After its transfer a query runs the bound check (a read of the last entry, then a
// compare), then binary probes (at most about log2 of the searched span, plus one),
// then a walk back over equal entries. The result is loaded in ST_PROBE_RD on a miss,
// in ST_WALK_RD on a walk stopped by start_index, in ST_WALK_CMP on a walk stopped by
// an unequal entry and in ST_CHK_CMP when the key is beyond the end; then back to idle.
// Every probe is a table read then a compare, one RAM read port.
// Reset clears control and last_index; the table is not cleared.
// A query waits at its last step while the previous result has not been taken.
module sorted_table_lower_bound_search #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sltbs_req_if.sink                   req,
	sltbs_rsp_if.source                 rsp,
	input  logic                        cfg_we,
	input  logic [sltbs_pkg::IDX_W-1:0] cfg_wdata
);

	sltbs_pkg::cmd_t    cmd;
	sltbs_pkg::status_t status;

	sltbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_op     (req.op),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.status    (status)
	);

	sltbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.entry_index (req.entry_index),
		.entry_value (req.entry_value),
		.start_index (req.start_index),
		.key         (req.key),
		.cmd         (cmd),
		.status      (status),
		.position    (rsp.position),
		.found       (rsp.found),
		.beyond_end  (rsp.beyond_end)
	);

endmodule

// File: src/sltbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sltbs_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, hold when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/sltbs_ctrl.sv
// Search sequencer: walks the bound check, binary probes and duplicate walk.
// Depends on sltbs_pkg; drives the datapath through cmd_t, reads status_t.
module sltbs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_op,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output sltbs_pkg::cmd_t     cmd,
	input  sltbs_pkg::status_t  status
);

	sltbs_pkg::state_t state_q, state_d;
	logic              out_valid_q;
	logic              out_busy;
	logic              accept;

	assign out_valid = out_valid_q;
	assign out_busy  = out_valid_q && !out_ready;
	assign in_ready  = (state_q == sltbs_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sltbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result slot: set on load, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.rd_sel     = sltbs_pkg::RD_NONE;
		cmd.res_sel    = sltbs_pkg::RES_MISS;
		unique case (state_q)
			sltbs_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_op == sltbs_pkg::OP_LOAD) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						state_d     = sltbs_pkg::ST_CHK_RD;
					end
				end
			end
			sltbs_pkg::ST_CHK_RD: begin
				cmd.rd_sel = sltbs_pkg::RD_HI;
				state_d    = sltbs_pkg::ST_CHK_CMP;
			end
			sltbs_pkg::ST_CHK_CMP: begin
				if (!status.beyond) begin
					state_d = sltbs_pkg::ST_PROBE_RD;
				end else if (!out_busy) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = sltbs_pkg::RES_BEYOND;
					state_d      = sltbs_pkg::ST_IDLE;
				end
			end
			sltbs_pkg::ST_PROBE_RD: begin
				if (status.loop_ok) begin
					cmd.rd_sel = sltbs_pkg::RD_MID;
					state_d    = sltbs_pkg::ST_PROBE_CMP;
				end else if (!out_busy) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = sltbs_pkg::RES_MISS;
					state_d      = sltbs_pkg::ST_IDLE;
				end
			end
			sltbs_pkg::ST_PROBE_CMP: begin
				if (status.eq) begin
					cmd.hit_mark = 1'b1;
					state_d      = sltbs_pkg::ST_WALK_RD;
				end else begin
					cmd.probe_step = 1'b1;
					state_d        = sltbs_pkg::ST_PROBE_RD;
				end
			end
			sltbs_pkg::ST_WALK_RD: begin
				if (status.walk_ok) begin
					cmd.rd_sel = sltbs_pkg::RD_PREV;
					state_d    = sltbs_pkg::ST_WALK_CMP;
				end else if (!out_busy) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = sltbs_pkg::RES_HIT;
					state_d      = sltbs_pkg::ST_IDLE;
				end
			end
			sltbs_pkg::ST_WALK_CMP: begin
				if (status.eq) begin
					cmd.walk_dec = 1'b1;
					state_d      = sltbs_pkg::ST_WALK_RD;
				end else if (!out_busy) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = sltbs_pkg::RES_HIT;
					state_d      = sltbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sltbs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: src/sltbs_dp.sv
// Search datapath: table RAM, search bounds, compare logic and result register.
// Depends on sltbs_pkg and sltbs_ram; controlled by sltbs_ctrl.
module sltbs_dp #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sltbs_pkg::IDX_W-1:0]         cfg_wdata,
	input  logic [sltbs_pkg::IDX_W-1:0]         entry_index,
	input  logic signed [sltbs_pkg::VAL_W-1:0]  entry_value,
	input  logic [sltbs_pkg::IDX_W-1:0]         start_index,
	input  logic signed [sltbs_pkg::VAL_W-1:0]  key,
	input  sltbs_pkg::cmd_t                     cmd,
	output sltbs_pkg::status_t                  status,
	output logic [sltbs_pkg::POS_W-1:0]         position,
	output logic                                found,
	output logic                                beyond_end
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);

	logic [sltbs_pkg::IDX_W-1:0]        last_index_q;
	logic [sltbs_pkg::IDX_W-1:0]        last_sat;
	logic signed [sltbs_pkg::VAL_W-1:0] key_q;
	logic signed [sltbs_pkg::CNT_W-1:0] lo_q;
	logic signed [sltbs_pkg::CNT_W-1:0] hi_q;
	logic [sltbs_pkg::IDX_W-1:0]        lb_q;
	logic [sltbs_pkg::IDX_W-1:0]        mid_q;
	logic [sltbs_pkg::IDX_W-1:0]        k_q;
	logic [sltbs_pkg::CNT_W-1:0]        mid_sum;
	logic [sltbs_pkg::IDX_W-1:0]        mid_c;
	logic [sltbs_pkg::IDX_W-1:0]        rd_idx;
	logic                               rd_en;
	logic                               wr_ok;
	logic signed [sltbs_pkg::VAL_W-1:0] rdata;
	logic [sltbs_pkg::VAL_W-1:0]        rdata_raw;
	logic [sltbs_pkg::POS_W-1:0]        pos_q;
	logic                               found_q;
	logic                               beyond_q;

	// Upper bound register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= '0;
		end else if (cfg_we) begin
			last_index_q <= cfg_wdata;
		end
	end

	// Clamp the upper bound to the table
	assign last_sat = (32'(last_index_q) > 32'(TABLE_DEPTH - 1)) ?
		sltbs_pkg::IDX_W'(TABLE_DEPTH - 1) : last_index_q;

	// Probe midpoint; bounds are non-negative whenever a probe runs
	assign mid_sum = sltbs_pkg::CNT_W'(lo_q[sltbs_pkg::IDX_W:0])
		+ sltbs_pkg::CNT_W'(hi_q[sltbs_pkg::IDX_W:0]);
	assign mid_c   = mid_sum[sltbs_pkg::IDX_W:1];

	// Read address select
	always_comb begin
		unique case (cmd.rd_sel)
			sltbs_pkg::RD_HI:   rd_idx = hi_q[sltbs_pkg::IDX_W-1:0];
			sltbs_pkg::RD_MID:  rd_idx = mid_c;
			sltbs_pkg::RD_PREV: rd_idx = k_q - sltbs_pkg::IDX_W'(1);
			default:            rd_idx = '0;
		endcase
	end
	assign rd_en = (cmd.rd_sel != sltbs_pkg::RD_NONE);

	// Loads beyond the table are dropped
	assign wr_ok = cmd.wr_en && (32'(entry_index) < 32'(TABLE_DEPTH));

	sltbs_ram #(
		.WIDTH (sltbs_pkg::VAL_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_ok),
		.waddr (AW'(entry_index)),
		.wdata (entry_value),
		.re    (rd_en),
		.raddr (AW'(rd_idx)),
		.rdata (rdata_raw)
	);
	assign rdata = rdata_raw;

	// Search bounds and walk index
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q <= key;
			lo_q  <= sltbs_pkg::CNT_W'(start_index);
			lb_q  <= start_index;
			hi_q  <= sltbs_pkg::CNT_W'(last_sat);
		end else if (cmd.probe_step) begin
			if (key_q < rdata) begin
				hi_q <= sltbs_pkg::CNT_W'(mid_q) - sltbs_pkg::CNT_W'(1);
			end else begin
				lo_q <= sltbs_pkg::CNT_W'(mid_q) + sltbs_pkg::CNT_W'(1);
			end
		end
		if (cmd.rd_sel == sltbs_pkg::RD_MID) begin
			mid_q <= mid_c;
		end
		if (cmd.hit_mark) begin
			k_q <= mid_q;
		end else if (cmd.walk_dec) begin
			k_q <= k_q - sltbs_pkg::IDX_W'(1);
		end
	end

	// Compare results for the controller
	assign status.beyond  = (rdata < key_q);
	assign status.eq      = (rdata == key_q);
	assign status.loop_ok = (lo_q <= hi_q);
	assign status.walk_ok = (k_q > lb_q);

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_sel)
				sltbs_pkg::RES_BEYOND: begin
					pos_q    <= '0;
					found_q  <= 1'b0;
					beyond_q <= 1'b1;
				end
				sltbs_pkg::RES_HIT: begin
					pos_q    <= sltbs_pkg::POS_W'(k_q);
					found_q  <= 1'b1;
					beyond_q <= 1'b0;
				end
				default: begin
					pos_q    <= lo_q[sltbs_pkg::POS_W-1:0];
					found_q  <= 1'b0;
					beyond_q <= 1'b0;
				end
			endcase
		end
	end

	assign position   = pos_q;
	assign found      = found_q;
	assign beyond_end = beyond_q;

endmodule

// File: sim/tb_sorted_table_lower_bound_search.sv
// Testbench for sorted_table_lower_bound_search: table loads and lower-bound searches
// over valid/ready channels, each result checked against an in-bench search model.
// Depends on sltbs_pkg, sltbs_req_if, sltbs_rsp_if and the block's RTL.
module tb_sorted_table_lower_bound_search;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH          = 1024;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned SETTLE_CYCLES  = 16;
	localparam int unsigned TAIL_CYCLES    = 64;
	localparam int unsigned STALL_CYCLES   = 400;
	localparam logic signed [sltbs_pkg::VAL_W-1:0] VAL_MIN =
		{1'b1, {(sltbs_pkg::VAL_W-1){1'b0}}};
	localparam logic signed [sltbs_pkg::VAL_W-1:0] VAL_MAX =
		{1'b0, {(sltbs_pkg::VAL_W-1){1'b1}}};

	typedef struct packed {
		logic [sltbs_pkg::POS_W-1:0] position;
		logic                        found;
		logic                        beyond_end;
	} search_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we;
	logic [sltbs_pkg::IDX_W-1:0] cfg_wdata;

	sltbs_req_if req_ch ();
	sltbs_rsp_if rsp_ch ();

	sorted_table_lower_bound_search #(.TABLE_DEPTH(DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Search model state: a copy of the table and of the last-index register
	logic signed [sltbs_pkg::VAL_W-1:0] entry_copy [DEPTH];
	logic [sltbs_pkg::IDX_W-1:0]        last_copy;
	search_result_t                     pending_results [$];
	search_result_t                     oldest_result;

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int stall_left   = 0;
	int quiet_cycles = 0;
	int error_count  = 0;
	int loads_sent   = 0;
	int searches_sent = 0;
	int results_checked = 0;
	int cfg_writes   = 0;

	always #4 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Lower-bound search over the model table, same probe order as the block
	function automatic search_result_t predict_search(logic [sltbs_pkg::IDX_W-1:0] start,
			logic signed [sltbs_pkg::VAL_W-1:0] key);
		int lo;
		int hi;
		int mid;
		int k;
		bit hit;
		search_result_t res;
		lo  = int'(start);
		hi  = int'(last_copy);
		k   = 0;
		hit = 1'b0;
		res = '0;
		if (entry_copy[hi] < key) begin
			res.beyond_end = 1'b1;
			return res;
		end
		while (lo <= hi && !hit) begin
			mid = (lo + hi) / 2;
			if (entry_copy[mid] == key) begin
				hit = 1'b1;
				k   = mid;
			end else if (key < entry_copy[mid]) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		// walk back over equal entries, never below the start index
		if (hit) begin
			while (k > int'(start) && entry_copy[k-1] == entry_copy[k])
				k--;
			res.position = sltbs_pkg::POS_W'(k);
		end else begin
			res.position = sltbs_pkg::POS_W'(lo);
		end
		res.found = hit;
		return res;
	endfunction

	// Next value of an ascending run: equal, a small step or a large one
	function automatic logic signed [sltbs_pkg::VAL_W-1:0] next_sorted(
			logic signed [sltbs_pkg::VAL_W-1:0] v);
		logic signed [sltbs_pkg::VAL_W-1:0] step;
		case ($urandom_range(9))
			0, 1, 2: step = '0;
			3, 4, 5: step = sltbs_pkg::VAL_W'($urandom_range(1, 3));
			default: step = sltbs_pkg::VAL_W'($urandom) << $urandom_range(0, 20);
		endcase
		if (v > VAL_MAX - step)
			return VAL_MAX;
		return v + step;
	endfunction

	// Offer one item, with random idle cycles first, and hold it until transfer
	task automatic send_item(logic op, logic [sltbs_pkg::IDX_W-1:0] idx,
			logic signed [sltbs_pkg::VAL_W-1:0] val, logic [sltbs_pkg::IDX_W-1:0] start,
			logic signed [sltbs_pkg::VAL_W-1:0] key);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.op          <= op;
		req_ch.entry_index <= idx;
		req_ch.entry_value <= val;
		req_ch.start_index <= start;
		req_ch.key         <= key;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		if (op == sltbs_pkg::OP_LOAD) begin
			entry_copy[idx] = val;
			loads_sent++;
		end else begin
			pending_results.push_back(predict_search(start, key));
			searches_sent++;
		end
	endtask

	task automatic load_entry(int idx, logic signed [sltbs_pkg::VAL_W-1:0] val);
		send_item(sltbs_pkg::OP_LOAD, sltbs_pkg::IDX_W'(idx), val,
			sltbs_pkg::IDX_W'($urandom), rand64());
	endtask

	task automatic search(int start, logic signed [sltbs_pkg::VAL_W-1:0] key);
		send_item(sltbs_pkg::OP_QUERY, sltbs_pkg::IDX_W'($urandom), rand64(),
			sltbs_pkg::IDX_W'(start), key);
	endtask

	// Drop valid and hold off until every expected result has arrived
	task automatic wait_drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Write the bound only while the block is idle
	task automatic set_last_index(logic [sltbs_pkg::IDX_W-1:0] value);
		wait_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		last_copy = value;
		cfg_writes++;
	endtask

	task automatic report_mismatch(string field, logic [63:0] exp_v, logic [63:0] act_v);
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
		error_count++;
	endtask

	// Receiver: random ready, or a long hold-off when one is requested
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: position %0d found %0b beyond_end %0b",
					$time, rsp_ch.position, rsp_ch.found, rsp_ch.beyond_end);
				error_count++;
			end else begin
				oldest_result = pending_results.pop_front();
				results_checked++;
				if (rsp_ch.position !== oldest_result.position)
					report_mismatch("position", oldest_result.position, rsp_ch.position);
				if (rsp_ch.found !== oldest_result.found)
					report_mismatch("found", oldest_result.found, rsp_ch.found);
				if (rsp_ch.beyond_end !== oldest_result.beyond_end)
					report_mismatch("beyond_end", oldest_result.beyond_end, rsp_ch.beyond_end);
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog: no transfer for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Reset value of the bound: a single written entry at index zero
	task automatic test_reset_defaults();
		load_entry(0, 64'sd100);
		search(0, 64'sd100);
		search(0, 64'sd99);
		search(0, 64'sd101);
		search(DEPTH - 1, 64'sd100);
		search(0, VAL_MIN);
		search(0, VAL_MAX);
	endtask

	// Fill the whole table in ascending order: minimum at the bottom, a long
	// run of equal values in the middle, a run of maximum values at the top
	task automatic test_table_fill();
		logic signed [sltbs_pkg::VAL_W-1:0] v;
		set_last_index({sltbs_pkg::IDX_W{1'b1}});
		v = VAL_MIN;
		for (int i = 0; i < DEPTH; i++) begin
			if (i >= DEPTH - 4)
				v = VAL_MAX;
			else if (i > 0 && !(i > 500 && i < 564))
				v = next_sorted(v);
			load_entry(i, v);
		end
	endtask

	// Duplicate walks, start bound, beyond-end and start above last
	task automatic test_duplicates_and_bounds();
		search(0, VAL_MIN);
		search(0, VAL_MAX);
		search(DEPTH - 2, VAL_MAX);
		search(0, entry_copy[530]);
		search(530, entry_copy[530]);
		search(0, entry_copy[700] + 1);
		search(DEPTH - 1, entry_copy[100]);
		set_last_index(sltbs_pkg::IDX_W'(700));
		search(0, entry_copy[700] + 1);
		search(DEPTH - 1, VAL_MIN);
		set_last_index('0);
		search(0, VAL_MIN);
		search(0, VAL_MIN + 1);
	endtask

	// Break the order inside the searched range and probe around it
	task automatic test_unsorted_table();
		set_last_index(sltbs_pkg::IDX_W'(31));
		load_entry(12, VAL_MAX);
		load_entry(20, VAL_MIN);
		search(0, entry_copy[25]);
		search(0, entry_copy[5]);
		search(13, VAL_MIN);
	endtask

	// Hold the receiver off while searches keep coming, then let it all drain
	task automatic test_output_stall();
		int idx;
		set_last_index({sltbs_pkg::IDX_W{1'b1}});
		src_idle_pct = 0;
		snk_idle_pct = 0;
		stall_left = STALL_CYCLES;
		repeat (24) begin
			idx = $urandom_range(DEPTH - 1);
			search($urandom_range(idx), entry_copy[idx]);
		end
		wait_drain();
		repeat (8)
			search($urandom_range(DEPTH - 1), rand64());
	endtask

	// Rounds of: maybe a new bound, a sorted window loaded below it, then
	// searches mostly inside the window with a little load noise mixed in
	task automatic run_random_phase(int src_pct, int snk_pct, int item_budget);
		int sent;
		int lo_idx;
		int last_int;
		int idx_pick;
		int start_pick;
		int roll;
		logic [sltbs_pkg::IDX_W-1:0]        next_last;
		logic signed [sltbs_pkg::VAL_W-1:0] v;
		logic signed [sltbs_pkg::VAL_W-1:0] key;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		sent = 0;
		while (sent < item_budget) begin
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(9))
					0:       next_last = '0;
					1:       next_last = '1;
					2, 3:    next_last = sltbs_pkg::IDX_W'($urandom_range(40));
					default: next_last = sltbs_pkg::IDX_W'($urandom);
				endcase
				set_last_index(next_last);
			end
			last_int = int'(last_copy);
			lo_idx = last_int - int'($urandom_range(24));
			if (lo_idx < 0)
				lo_idx = 0;
			case ($urandom_range(4))
				0:       v = VAL_MIN;
				1:       v = VAL_MAX - sltbs_pkg::VAL_W'($urandom_range(40));
				default: v = rand64();
			endcase
			for (int i = lo_idx; i <= last_int; i++) begin
				load_entry(i, v);
				v = next_sorted(v);
				sent++;
			end
			repeat ($urandom_range(6, 14)) begin
				if ($urandom_range(9) == 0) begin
					load_entry($urandom_range(DEPTH - 1), rand64());
				end else begin
					roll = $urandom_range(9);
					if (roll < 6)
						start_pick = lo_idx + $urandom_range(last_int - lo_idx);
					else if (roll == 6)
						start_pick = lo_idx;
					else if (roll == 7)
						start_pick = last_int;
					else if (roll == 8 || last_int == DEPTH - 1)
						start_pick = $urandom_range(DEPTH - 1);
					else
						start_pick = $urandom_range(DEPTH - 1, last_int + 1);
					idx_pick = lo_idx + $urandom_range(last_int - lo_idx);
					roll = $urandom_range(19);
					if (roll < 10)
						key = entry_copy[idx_pick];
					else if (roll < 12)
						key = entry_copy[idx_pick] - 1;
					else if (roll < 14)
						key = entry_copy[idx_pick] + 1;
					else if (roll < 16)
						key = entry_copy[last_int] + 1;
					else if (roll == 16)
						key = VAL_MIN;
					else if (roll == 17)
						key = VAL_MAX;
					else
						key = rand64();
					search(start_pick, key);
				end
				sent++;
			end
		end
	endtask

	initial begin
		req_ch.valid       = 1'b0;
		req_ch.op          = sltbs_pkg::OP_LOAD;
		req_ch.entry_index = '0;
		req_ch.entry_value = '0;
		req_ch.start_index = '0;
		req_ch.key         = '0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		last_copy          = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_table_fill();
		test_duplicates_and_bounds();
		test_unsorted_table();
		test_output_stall();
		run_random_phase(27, 67, 110);
		run_random_phase(67, 27, 110);
		run_random_phase(0, 0, 120);

		// let everything drain, then watch for stray results
		wait_drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Run covered %0d loads and %0d searches, %0d results checked, %0d bound writes.",
			loads_sent, searches_sent, results_checked, cfg_writes);
		$display("Idle mixes 27/67, 67/27 and none, plus a %0d-cycle receiver hold-off.",
			STALL_CYCLES);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
